>>> rtl/core/sdsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdsp_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ENABLE   = 3'd6;

	// register reset values
	localparam logic signed [15:0] GAIN_P_RST         = 16'sd30;
	localparam logic signed [15:0] GAIN_I_RST         = 16'sd1;
	localparam logic signed [15:0] GAIN_D_RST         = 16'sd1;
	localparam logic [14:0]        ERROR_LIMIT_RST    = 15'd15;
	localparam logic [15:0]        PWM_PERIOD_RST     = 16'd4000;
	localparam logic [14:0]        INTEGRAL_LIMIT_RST = 15'd4096;
	localparam logic               MOTOR_ENABLE_RST   = 1'b1;

	// drive code bit positions
	localparam int unsigned DRV_EN_BIT  = 0;
	localparam int unsigned DRV_POS_BIT = 1;

	// error / integral stage word
	typedef struct packed {
		logic               valid;
		logic signed [15:0] err;
		logic signed [15:0] integ;
		logic signed [16:0] derr;
		logic               fault;
	} stg1_t;

	// product stage word
	typedef struct packed {
		logic               valid;
		logic signed [31:0] prod_p;
		logic signed [31:0] prod_i;
		logic signed [31:0] prod_d;
		logic signed [15:0] err;
		logic               fault;
	} stg2_t;

endpackage

`default_nettype wire

>>> rtl/core/sdsp_err.sv
`timescale 1ns / 1ps
`default_nettype none

module sdsp_err (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [15:0]         step_count,
	input  wire  [15:0]         quad_count,
	input  wire  [14:0]         error_limit,
	input  wire  [14:0]         integral_limit,
	input  wire                 fault_clr,
	input  wire                 down_stall,
	output sdsp_pkg::stg1_t     s1
);
	import sdsp_pkg::*;

	logic [15:0]        prev_step_q;
	logic [15:0]        prev_quad_q;
	logic signed [15:0] err_q;
	logic signed [15:0] integ_q;
	logic               fault_q;

	logic               accept;
	logic [15:0]        step_dlt;
	logic [15:0]        quad_dlt;
	logic signed [15:0] err_nxt;
	logic signed [16:0] err_x;
	logic signed [16:0] elim_x;
	logic               exceed;
	logic signed [15:0] integ_sum;
	logic signed [15:0] ilim;
	logic signed [15:0] integ_nxt;
	logic signed [16:0] derr_nxt;

	// stage holds while its word cannot move on
	assign in_stall = s1.valid && down_stall;
	assign accept   = in_valid && !in_stall;

	// modular counter deltas into the wrapping error
	always_comb begin
		step_dlt = step_count - prev_step_q;
		quad_dlt = quad_count - prev_quad_q;
		err_nxt  = $signed(err_q + step_dlt - quad_dlt);
	end

	// fault window check
	always_comb begin
		err_x  = {err_nxt[15], err_nxt};
		elim_x = $signed({2'b00, error_limit});
		exceed = (err_x > elim_x) || (err_x < -elim_x);
	end

	// integral with wrap, then symmetric clamp
	always_comb begin
		integ_sum = integ_q + err_nxt;
		ilim      = $signed({1'b0, integral_limit});
		if (integ_sum > ilim) begin
			integ_nxt = ilim;
		end else if (integ_sum < -ilim) begin
			integ_nxt = -ilim;
		end else begin
			integ_nxt = integ_sum;
		end
		// previous error is the accumulator before this update
		derr_nxt = {err_nxt[15], err_nxt} - {err_q[15], err_q};
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_step_q <= '0;
			prev_quad_q <= '0;
			err_q       <= '0;
			integ_q     <= '0;
			fault_q     <= 1'b0;
		end else begin
			if (accept) begin
				prev_step_q <= step_count;
				prev_quad_q <= quad_count;
				err_q       <= err_nxt;
				integ_q     <= integ_nxt;
			end
			if (fault_clr) begin
				fault_q <= 1'b0;
			end else if (accept && exceed) begin
				fault_q <= 1'b1;
			end
		end
	end

	// stage valid and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else begin
			if (!in_stall) begin
				s1.valid <= in_valid;
			end
			if (accept) begin
				s1.err   <= err_nxt;
				s1.integ <= integ_nxt;
				s1.derr  <= derr_nxt;
				s1.fault <= fault_q || exceed;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sdsp_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module sdsp_mul (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire sdsp_pkg::stg1_t s1,
	output logic                up_stall,
	input  wire  signed [15:0]  gain_p,
	input  wire  signed [15:0]  gain_i,
	input  wire  signed [15:0]  gain_d,
	input  wire                 down_stall,
	output sdsp_pkg::stg2_t     s2
);
	import sdsp_pkg::*;

	logic               load;
	logic signed [31:0] prod_p;
	logic signed [31:0] prod_i;
	logic signed [32:0] prod_d_full;

	assign up_stall = s2.valid && down_stall;
	assign load     = s1.valid && !up_stall;

	// three independent products
	always_comb begin
		prod_p      = gain_p * s1.err;
		prod_i      = gain_i * s1.integ;
		prod_d_full = gain_d * s1.derr;
	end

	// stage valid and payload, derivative product wraps to 32 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2 <= '0;
		end else begin
			if (!up_stall) begin
				s2.valid <= s1.valid;
			end
			if (load) begin
				s2.prod_p <= prod_p;
				s2.prod_i <= prod_i;
				s2.prod_d <= prod_d_full[31:0];
				s2.err    <= s1.err;
				s2.fault  <= s1.fault;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sdsp_out.sv
`timescale 1ns / 1ps
`default_nettype none

module sdsp_out (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire sdsp_pkg::stg2_t s2,
	output logic                up_stall,
	input  wire  [15:0]         pwm_period,
	input  wire                 motor_enable,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [15:0]         pwm_compare,
	output logic [1:0]          drive_code,
	output logic signed [31:0]  pid_value,
	output logic signed [15:0]  position_error,
	output logic                fault
);
	import sdsp_pkg::*;

	logic               valid_s3;
	logic signed [31:0] pid_s3;
	logic signed [15:0] err_s3;
	logic               fault_s3;

	logic               out_hold;
	logic               s3_hold;
	logic               load_s3;
	logic               load_out;
	logic [31:0]        mag;
	logic [15:0]        cmp;
	logic [1:0]         code;

	assign out_hold = out_valid && out_stall;
	assign s3_hold  = valid_s3 && out_hold;
	assign up_stall = s3_hold;
	assign load_s3  = s2.valid && !s3_hold;
	assign load_out = valid_s3 && !out_hold;

	// sum stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (!s3_hold) begin
			valid_s3 <= s2.valid;
		end
	end

	// wrapping pid sum
	always_ff @(posedge clk) begin
		if (load_s3) begin
			pid_s3   <= s2.prod_p + s2.prod_i + s2.prod_d;
			err_s3   <= s2.err;
			fault_s3 <= s2.fault;
		end
	end

	// magnitude, cap and drive code
	always_comb begin
		mag = pid_s3[31] ? (32'd0 - pid_s3) : pid_s3;
		cmp = (mag > {16'd0, pwm_period}) ? pwm_period : mag[15:0];
		code = '0;
		code[DRV_POS_BIT] = (pid_s3 != '0) && !pid_s3[31];
		code[DRV_EN_BIT]  = (pid_s3 != '0) && motor_enable;
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_hold) begin
			out_valid <= valid_s3;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			pwm_compare    <= cmp;
			drive_code     <= code;
			pid_value      <= pid_s3;
			position_error <= err_s3;
			fault          <= fault_s3;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/step_dir_servo_pid_core.sv
// step/direction servo pid position controller
// an accepted input word is registered in s1, s2, the pid sum stage and the output word before out_valid
// throughput: one word per cycle unless out_stall holds a full pipeline; any stage accepts while a later one is free
// pipeline: error/integral update, products, pid sum, magnitude/cap/code
// reset: asynchronous active low; state clears to zero, registers to defaults
`timescale 1ns / 1ps
`default_nettype none

module step_dir_servo_pid_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr_en,
	input  wire  [2:0]          cfg_index,
	input  wire  [15:0]         cfg_data,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [15:0]         step_count,
	input  wire  [15:0]         quad_count,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [15:0]         pwm_compare,
	output logic [1:0]          drive_code,
	output logic signed [31:0]  pid_value,
	output logic signed [15:0]  position_error,
	output logic                fault
);
	import sdsp_pkg::*;

	logic signed [15:0] gain_p_q;
	logic signed [15:0] gain_i_q;
	logic signed [15:0] gain_d_q;
	logic [14:0]        error_limit_q;
	logic [15:0]        pwm_period_q;
	logic [14:0]        integral_limit_q;
	logic               motor_enable_q;

	logic               fault_clr;
	logic               s2_hold;
	logic               s3_hold;
	stg1_t              s1;
	stg2_t              s2;

	// any write to a known register clears the sticky fault
	always_comb begin
		fault_clr = 1'b0;
		if (cfg_wr_en) begin
			case (cfg_index)
				REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_ERROR_LIMIT,
				REG_PWM_PERIOD, REG_INTEGRAL_LIMIT, REG_MOTOR_ENABLE: begin
					fault_clr = 1'b1;
				end
				default: begin
					fault_clr = 1'b0;
				end
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q         <= GAIN_P_RST;
			gain_i_q         <= GAIN_I_RST;
			gain_d_q         <= GAIN_D_RST;
			error_limit_q    <= ERROR_LIMIT_RST;
			pwm_period_q     <= PWM_PERIOD_RST;
			integral_limit_q <= INTEGRAL_LIMIT_RST;
			motor_enable_q   <= MOTOR_ENABLE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GAIN_P:         gain_p_q         <= $signed(cfg_data);
				REG_GAIN_I:         gain_i_q         <= $signed(cfg_data);
				REG_GAIN_D:         gain_d_q         <= $signed(cfg_data);
				REG_ERROR_LIMIT:    error_limit_q    <= cfg_data[14:0];
				REG_PWM_PERIOD:     pwm_period_q     <= cfg_data;
				REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[14:0];
				REG_MOTOR_ENABLE:   motor_enable_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// error, fault and integral update
	sdsp_err u_err (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.step_count     (step_count),
		.quad_count     (quad_count),
		.error_limit    (error_limit_q),
		.integral_limit (integral_limit_q),
		.fault_clr      (fault_clr),
		.down_stall     (s2_hold),
		.s1             (s1)
	);

	// gain products
	sdsp_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1         (s1),
		.up_stall   (s2_hold),
		.gain_p     (gain_p_q),
		.gain_i     (gain_i_q),
		.gain_d     (gain_d_q),
		.down_stall (s3_hold),
		.s2         (s2)
	);

	// pid sum and output word
	sdsp_out u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.s2             (s2),
		.up_stall       (s3_hold),
		.pwm_period     (pwm_period_q),
		.motor_enable   (motor_enable_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pwm_compare    (pwm_compare),
		.drive_code     (drive_code),
		.pid_value      (pid_value),
		.position_error (position_error),
		.fault          (fault)
	);

endmodule

`default_nettype wire

>>> tb/tb_step_dir_servo_pid_core.sv
`timescale 1ns / 1ps

module tb_step_dir_servo_pid_core;
	import sdsp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int CFG_SETTLE = 6;
	localparam int HOLD_CYCLES = 120;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 130;
	localparam int DIR_ROWS = 25;

	// index past the register file, must be ignored
	localparam logic [2:0] REG_NONE = 3'd7;

	// drive codes
	localparam logic [1:0] DRIVE_IDLE = 2'b00;
	localparam logic [1:0] DRIVE_REV  = 2'b01;
	localparam logic [1:0] DRIVE_FWD  = 2'b11;

	typedef struct packed {
		logic [15:0] cmp;
		logic [1:0]  code;
		logic [31:0] pid;
		logic [15:0] err;
		logic        flt;
	} servo_out_t;

	typedef enum logic [1:0] {ROW_WORD, ROW_CHECK, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e   kind;
		logic [2:0]  idx;
		logic [15:0] data;
		logic [15:0] s;
		logic [15:0] q;
		servo_out_t  want;
	} stim_row_t;

	typedef enum {CFG_TUNED, CFG_WILD, CFG_MAX, CFG_MIN} cfg_style_e;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [15:0]        step_count = '0;
	logic [15:0]        quad_count = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        pwm_compare;
	logic [1:0]         drive_code;
	logic signed [31:0] pid_value;
	logic signed [15:0] position_error;
	logic               fault;

	step_dir_servo_pid_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.step_count     (step_count),
		.quad_count     (quad_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pwm_compare    (pwm_compare),
		.drive_code     (drive_code),
		.pid_value      (pid_value),
		.position_error (position_error),
		.fault          (fault)
	);

	always #6 clk = ~clk;

	// controller settings as the block should hold them
	int          kp = GAIN_P_RST;
	int          ki = GAIN_I_RST;
	int          kd = GAIN_D_RST;
	logic [14:0] err_lim = ERROR_LIMIT_RST;
	logic [15:0] pwm_top = PWM_PERIOD_RST;
	logic [14:0] integ_lim = INTEGRAL_LIMIT_RST;
	logic        motor_on = MOTOR_ENABLE_RST;

	// loop state
	logic [15:0] pos_err = '0;
	logic [15:0] last_err = '0;
	logic [15:0] integ_acc = '0;
	logic [15:0] last_step = '0;
	logic [15:0] last_quad = '0;
	logic        fault_seen = 1'b0;

	servo_out_t  pid_q [$];
	int          fails = 0;
	int          cycles = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_cnt = 0;

	// register write as the block should apply it
	function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			REG_GAIN_P:         kp = $signed(data);
			REG_GAIN_I:         ki = $signed(data);
			REG_GAIN_D:         kd = $signed(data);
			REG_ERROR_LIMIT:    err_lim = data[14:0];
			REG_PWM_PERIOD:     pwm_top = data;
			REG_INTEGRAL_LIMIT: integ_lim = data[14:0];
			REG_MOTOR_ENABLE:   motor_on = data[0];
			default:            return;
		endcase
		fault_seen = 1'b0;
	endfunction

	// one control tick: error, clamped integral, pid sum, compare and drive code
	function automatic servo_out_t pid_tick(input logic [15:0] s, input logic [15:0] q);
		int          e;
		int          pe;
		int          de;
		int          ig;
		int          lim;
		logic [31:0] pid;
		logic [31:0] mag;
		servo_out_t  r;
		pos_err = pos_err + (s - last_step) - (q - last_quad);
		last_step = s;
		last_quad = q;
		e = $signed(pos_err);
		lim = {17'd0, err_lim};
		if (e > lim || e < -lim)
			fault_seen = 1'b1;
		integ_acc = integ_acc + pos_err;
		ig = $signed(integ_acc);
		lim = {17'd0, integ_lim};
		if (ig > lim)
			ig = lim;
		else if (ig < -lim)
			ig = -lim;
		integ_acc = ig[15:0];
		pe = $signed(last_err);
		de = e - pe;
		pid = kp * e + ig * ki + kd * de;
		last_err = pos_err;
		mag = pid[31] ? -pid : pid;
		r.cmp = (mag > {16'd0, pwm_top}) ? pwm_top : mag[15:0];
		r.code = '0;
		r.code[DRV_POS_BIT] = (pid != 0) && !pid[31];
		r.code[DRV_EN_BIT] = (pid != 0) && motor_on;
		r.pid = pid;
		r.err = pos_err;
		r.flt = fault_seen;
		return r;
	endfunction

	function automatic stim_row_t word_row(input logic [15:0] s, input logic [15:0] q);
		stim_row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.s = s;
		r.q = q;
		return r;
	endfunction

	function automatic stim_row_t check_row(input logic [15:0] s, input logic [15:0] q,
			input logic [15:0] cmp, input logic [1:0] code, input logic [31:0] pid,
			input logic [15:0] err, input logic flt);
		stim_row_t r;
		r = word_row(s, q);
		r.kind = ROW_CHECK;
		r.want = '{cmp: cmp, code: code, pid: pid, err: err, flt: flt};
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [15:0] data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic logic [15:0] reg_value(input logic [2:0] idx, input cfg_style_e style);
		case (style)
			CFG_MIN:  return (idx <= REG_GAIN_D) ? 16'h8000 : 16'h0000;
			CFG_MAX:  return (idx <= REG_GAIN_D) ? 16'h7FFF : 16'hFFFF;
			CFG_WILD: return 16'($urandom);
			default: begin
				case (idx)
					REG_ERROR_LIMIT:    return 16'($urandom_range(400, 4));
					REG_PWM_PERIOD:     return 16'($urandom_range(6000, 200));
					REG_INTEGRAL_LIMIT: return 16'($urandom_range(9000, 64));
					REG_MOTOR_ENABLE:   return 16'($urandom_range(1));
					default:            return 16'($urandom_range(96)) - 16'd32;
				endcase
			end
		endcase
	endfunction

	// offer one word, called after a rising edge; returns at the edge that takes it
	task automatic offer_word(input logic [15:0] s, input logic [15:0] q,
			input bit fixed, input servo_out_t fixed_out);
		servo_out_t got;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		step_count <= s;
		quad_count <= q;
		do @(posedge clk); while (in_stall);
		got = pid_tick(s, q);
		pid_q.push_back(fixed ? fixed_out : got);
	endtask

	// register write once the pipeline has drained
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pid_q.size() != 0)
			@(negedge clk);
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		apply_reg(idx, data);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	// output word checker and run timeout
	always @(posedge clk) begin
		servo_out_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL step_dir_servo_pid_core");
			$finish;
		end else if (arst_n && out_valid && !out_stall) begin
			if (pid_q.size() == 0) begin
				$error("output word with none expected");
				fails++;
			end else begin
				want = pid_q.pop_front();
				if (pwm_compare !== want.cmp) begin
					$error("pwm_compare: expected %0d, got %0d", want.cmp, pwm_compare);
					fails++;
				end
				if (drive_code !== want.code) begin
					$error("drive_code: expected %0d, got %0d", want.code, drive_code);
					fails++;
				end
				if (pid_value !== want.pid) begin
					$error("pid_value: expected %0d, got %0d", $signed(want.pid), pid_value);
					fails++;
				end
				if (position_error !== want.err) begin
					$error("position_error: expected %0d, got %0d", $signed(want.err),
						position_error);
					fails++;
				end
				if (fault !== want.flt) begin
					$error("fault: expected %0d, got %0d", want.flt, fault);
					fails++;
				end
			end
		end
	end

	initial begin
		stim_row_t   dir_tab [DIR_ROWS];
		cfg_style_e  plan [PHASES];
		logic [15:0] pos_s;
		logic [15:0] pos_q;
		logic [15:0] dstep;
		int          mode;

		plan = '{CFG_TUNED, CFG_WILD, CFG_TUNED, CFG_MAX, CFG_TUNED, CFG_MIN, CFG_WILD,
			CFG_TUNED};

		// directed: reset state, counter wrap, error extreme, most negative sum,
		// ignored index, zero error limit, disabled motor, integral wrap
		dir_tab = '{
			check_row(16'h0000, 16'h0000, 16'd0, DRIVE_IDLE, 32'd0, 16'h0000, 1'b0),
			check_row(16'h0001, 16'h0000, 16'd32, DRIVE_FWD, 32'd32, 16'h0001, 1'b0),
			check_row(16'hFFFF, 16'h0000, 16'd32, DRIVE_REV, 32'hFFFF_FFE0, 16'hFFFF, 1'b0),
			word_row(16'hFFFF, 16'hFFFF),
			cfg_row(REG_GAIN_P, 16'h8000),
			cfg_row(REG_GAIN_I, 16'h0000),
			cfg_row(REG_GAIN_D, 16'h8000),
			check_row(16'h7FFF, 16'hFFFF, 16'd4000, DRIVE_REV, 32'h8000_0000, 16'h8000, 1'b1),
			cfg_row(REG_NONE, 16'hFFFF),
			check_row(16'h7FFF, 16'hFFFF, 16'd4000, DRIVE_FWD, 32'h4000_0000, 16'h8000, 1'b1),
			cfg_row(REG_ERROR_LIMIT, 16'h0000),
			cfg_row(REG_PWM_PERIOD, 16'hFFFF),
			cfg_row(REG_INTEGRAL_LIMIT, 16'h7FFF),
			cfg_row(REG_MOTOR_ENABLE, 16'h0000),
			cfg_row(REG_GAIN_I, 16'h7FFF),
			cfg_row(REG_GAIN_P, 16'h7FFF),
			cfg_row(REG_GAIN_D, 16'h7FFF),
			word_row(16'h0000, 16'h0000),
			word_row(16'h7FFF, 16'h0000),
			word_row(16'hFFFF, 16'h8000),
			word_row(16'h0000, 16'h0001),
			cfg_row(REG_ERROR_LIMIT, 16'h7FFF),
			cfg_row(REG_MOTOR_ENABLE, 16'h0001),
			word_row(16'hAAAA, 16'h5555),
			word_row(16'h5555, 16'hAAAA)
		};

		// reset
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			case (dir_tab[i].kind)
				ROW_CFG:   write_reg(dir_tab[i].idx, dir_tab[i].data);
				ROW_CHECK: offer_word(dir_tab[i].s, dir_tab[i].q, 1'b1, dir_tab[i].want);
				default:   offer_word(dir_tab[i].s, dir_tab[i].q, 1'b0, '0);
			endcase
		end

		// random phases, each with its own settings and idling pattern
		pos_s = last_step;
		pos_q = last_quad;
		for (int p = 0; p < PHASES; p++) begin
			for (int r = REG_GAIN_P; r <= REG_MOTOR_ENABLE; r++)
				write_reg(3'(r), reg_value(3'(r), plan[p]));
			if (plan[p] == CFG_WILD)
				write_reg(REG_NONE, 16'($urandom));
			mode = p % 4;
			tx_idle_pct = (mode == 1) ? 48 : (mode == 3) ? 9 : 0;
			rx_stall_pct <= (mode == 2) ? 48 : (mode == 3) ? 9 : 0;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// long receiver hold-off while the sender keeps offering
				if (mode == 0 && n == 20)
					hold_req <= hold_req + 1;
				// mostly a tracking motor with small counter moves, some wild jumps
				if ($urandom_range(99) < 75) begin
					dstep = 16'($urandom_range(40)) - 16'd20;
					pos_s = pos_s + dstep;
					pos_q = pos_q + dstep + 16'($urandom_range(6)) - 16'd3;
				end else begin
					pos_s = 16'($urandom);
					pos_q = 16'($urandom);
				end
				offer_word(pos_s, pos_q, 1'b0, '0);
			end
		end

		// drain and verdict
		@(negedge clk);
		in_valid <= 1'b0;
		while (pid_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("PASS step_dir_servo_pid_core");
		else
			$display("FAIL step_dir_servo_pid_core");
		$finish;
	end

endmodule
